// ----- design/bdd_pkg.sv -----
// Shared types, constants and scaler helper functions for the Bayer demosaic/downscale block.
`default_nettype none

package bdd_pkg;

  localparam int PIX_BITS  = 8;
  localparam int POS_BITS  = 12;
  localparam int REG_BITS  = 13;
  localparam int ACC_BITS  = 25;
  localparam int POS_LIMIT = 4096;

  typedef logic [PIX_BITS-1:0] pix_t;
  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [REG_BITS-1:0] reg_t;
  typedef logic [ACC_BITS-1:0] acc_t;

  // configuration register indexes
  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_OUT_WIDTH  = 2'd2;
  localparam logic [1:0] REG_OUT_HEIGHT = 2'd3;

  // Scaler tracking for one axis at source coordinate c:
  // nd = next destination index, acc = nd * src, bound = c * dst.
  typedef struct packed {
    reg_t nd;
    acc_t acc;
    acc_t bound;
  } track_t;

  // One candidate centre coordinate on one axis.
  typedef struct packed {
    logic en;       // chosen by the scaler and due for output
    pos_t d;        // destination index
    logic last;     // d is the last destination index
    logic odd;      // source coordinate parity
    logic has_pre;  // source coordinate above zero (no edge replication)
  } axis_t;

  // pre: coordinate one behind the arriving sample, cur: the arriving coordinate itself
  typedef struct packed {
    axis_t pre;
    axis_t cur;
  } axis_pair_t;

  function automatic logic sel_cur(track_t t, pos_t c, reg_t src, reg_t dst);
    return ({1'b0, c} < src) && (t.nd < dst) && (t.acc < t.bound + acc_t'(dst));
  endfunction

  function automatic track_t trk_step(track_t t, pos_t c, reg_t src, reg_t dst);
    track_t n;
    logic   ch;
    ch      = sel_cur(t, c, src, dst);
    n.nd    = t.nd + reg_t'(ch);
    n.acc   = ch ? t.acc + acc_t'(src) : t.acc;
    n.bound = t.bound + acc_t'(dst);
    return n;
  endfunction

  function automatic axis_pair_t make_axis(track_t t, pos_t c, reg_t src, reg_t dst);
    axis_pair_t a;
    // c-1 is chosen when destination nd-1 still maps onto it
    a.pre.en      = (c != '0) && ({1'b0, c} <= src) && (t.nd != '0) && (t.nd <= dst) &&
                    (t.acc + acc_t'(dst) >= t.bound + acc_t'(src));
    a.pre.d       = pos_t'(t.nd - reg_t'(1));
    a.pre.last    = (t.nd == dst);
    a.pre.odd     = ~c[0];
    a.pre.has_pre = (c > pos_t'(1));
    a.cur.en      = ({1'b0, c} == src - reg_t'(1)) && sel_cur(t, c, src, dst);
    a.cur.d       = pos_t'(t.nd);
    a.cur.last    = (t.nd == dst - reg_t'(1));
    a.cur.odd     = c[0];
    a.cur.has_pre = (c != '0);
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- design/bayer_demosaic_downscale.sv -----
// Top level: streaming RGGB bilinear demosaic with nearest-neighbour downscaling.
//
// Input channel (in_valid/in_stall): one raw sample word per cycle in raster order while
// in_stall is low; frame_start puts the position counters at the origin before that sample.
// Output channel (out_valid/out_stall): RGB words with destination column/row,
// frame_done on the last output pixel, run_last on the last word caused by a sample.
// Config channel (cfg_valid/cfg_ready): index 0..3 = source width, source height,
// output width, output height; write only while the block is idle.
// Pipeline: sample register with line buffer read, window/descriptor stage, output
// register. A sample's first word passes these three registers in that order.
// Throughput: one sample per cycle while out_stall is low and each sample causes
// at most one word; a sample that causes more words holds the input while the single
// output register drains them, one word per cycle unless out_stall is high.
// A config write stalls the input while the scaler trackers replay to the current position.
// Reset: counters at the origin, registers at 640x480, window zero; line buffers
// are not cleared. A stalled output word holds and backs up into the input.
`default_nettype none

module bayer_demosaic_downscale #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bdd_pkg::PIX_BITS-1:0] raw_value,
  input  logic                       frame_start,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bdd_pkg::PIX_BITS-1:0] red,
  output logic [bdd_pkg::PIX_BITS-1:0] green,
  output logic [bdd_pkg::PIX_BITS-1:0] blue,
  output logic [bdd_pkg::POS_BITS-1:0] out_column,
  output logic [bdd_pkg::POS_BITS-1:0] out_row,
  output logic                       frame_done,
  output logic                       run_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [bdd_pkg::REG_BITS-1:0] cfg_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_SYNC = 2'd2;

  // configuration
  bdd_pkg::reg_t src_w_reg, src_h_reg, out_w_reg, out_h_reg;
  bdd_pkg::reg_t eff_sw, eff_sh, eff_ow, eff_oh;
  bdd_pkg::reg_t eff_sw_next, eff_sh_next, eff_ow_next, eff_oh_next;

  // position and scaler tracking
  logic [1:0]       state;
  bdd_pkg::pos_t    in_column, in_row, rep_col, rep_row;
  bdd_pkg::track_t  col_trk, row_trk;
  bdd_pkg::pos_t    x_now, y_now;
  bdd_pkg::track_t  ct_now, rt_now;
  bdd_pkg::axis_pair_t cols_now, rows_now;
  logic             x_wrap, y_wrap, in_acc;
  logic             inbuf_now;
  logic [AW-1:0]    addr_now;

  // line buffers
  bdd_pkg::pix_t    line1 [MAX_WIDTH];
  bdd_pkg::pix_t    line2 [MAX_WIDTH];
  bdd_pkg::pix_t    rd1, rd2;

  // sample stage
  logic             b_valid, b_xfer, b_inbuf;
  logic [AW-1:0]    b_addr;
  bdd_pkg::pix_t    b_pix, a1_b, a2_b;
  bdd_pkg::axis_pair_t b_cols, b_rows;

  // window stage
  bdd_pkg::pix_t    win [9];
  logic [3:0]       c_mask, c_mask_rest;
  bdd_pkg::axis_pair_t c_cols, c_rows;
  logic             c_free, d_load;

  // demosaic
  logic             rsel, csel;
  bdd_pkg::axis_t   ra, ca;
  logic [23:0]      row_top, row_mid, row_bot, ctr_row, up_row;
  logic [1:0]       ci, lf_i;
  bdd_pkg::pix_t    ctr, r_val, g_val, b_val;
  logic [8:0]       hsum, vsum;
  logic [9:0]       dsum, gsum;

  assign cfg_ready = 1'b1;

  // effective sizes after clamping
  always_comb begin
    eff_sw_next = src_w_reg;
    if (eff_sw_next == '0) eff_sw_next = bdd_pkg::reg_t'(1);
    else if (eff_sw_next > bdd_pkg::reg_t'(bdd_pkg::POS_LIMIT))
      eff_sw_next = bdd_pkg::reg_t'(bdd_pkg::POS_LIMIT);
    if (int'(eff_sw_next) > MAX_WIDTH) eff_sw_next = bdd_pkg::reg_t'(MAX_WIDTH);
    eff_sh_next = src_h_reg;
    if (eff_sh_next == '0) eff_sh_next = bdd_pkg::reg_t'(1);
    else if (eff_sh_next > bdd_pkg::reg_t'(bdd_pkg::POS_LIMIT))
      eff_sh_next = bdd_pkg::reg_t'(bdd_pkg::POS_LIMIT);
    eff_ow_next = out_w_reg;
    if (eff_ow_next == '0) eff_ow_next = bdd_pkg::reg_t'(1);
    else if (eff_ow_next > eff_sw_next) eff_ow_next = eff_sw_next;
    eff_oh_next = out_h_reg;
    if (eff_oh_next == '0) eff_oh_next = bdd_pkg::reg_t'(1);
    else if (eff_oh_next > eff_sh_next) eff_oh_next = eff_sh_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w_reg <= bdd_pkg::reg_t'(640);
      src_h_reg <= bdd_pkg::reg_t'(480);
      out_w_reg <= bdd_pkg::reg_t'(640);
      out_h_reg <= bdd_pkg::reg_t'(480);
      eff_sw    <= bdd_pkg::reg_t'(640);
      eff_sh    <= bdd_pkg::reg_t'(480);
      eff_ow    <= bdd_pkg::reg_t'(640);
      eff_oh    <= bdd_pkg::reg_t'(480);
    end else begin
      eff_sw <= eff_sw_next;
      eff_sh <= eff_sh_next;
      eff_ow <= eff_ow_next;
      eff_oh <= eff_oh_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bdd_pkg::REG_SRC_WIDTH:  src_w_reg <= cfg_data;
          bdd_pkg::REG_SRC_HEIGHT: src_h_reg <= cfg_data;
          bdd_pkg::REG_OUT_WIDTH:  out_w_reg <= cfg_data;
          bdd_pkg::REG_OUT_HEIGHT: out_h_reg <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // accept-side position logic
  assign in_stall = (state != ST_RUN) || (b_valid && !b_xfer);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    x_now     = frame_start ? '0 : in_column;
    y_now     = frame_start ? '0 : in_row;
    ct_now    = frame_start ? '0 : col_trk;
    rt_now    = frame_start ? '0 : row_trk;
    cols_now  = bdd_pkg::make_axis(ct_now, x_now, eff_sw, eff_ow);
    rows_now  = bdd_pkg::make_axis(rt_now, y_now, eff_sh, eff_oh);
    x_wrap    = ({1'b0, x_now} + bdd_pkg::reg_t'(1)) >= eff_sw;
    y_wrap    = ({1'b0, y_now} + bdd_pkg::reg_t'(1)) >= eff_sh;
    inbuf_now = int'(x_now) < MAX_WIDTH;
    addr_now  = AW'(x_now);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      in_column <= '0;
      in_row    <= '0;
      col_trk   <= '0;
      row_trk   <= '0;
      rep_col   <= '0;
      rep_row   <= '0;
    end else begin
      case (state)
        ST_RUN: begin
          if (in_acc) begin
            if (x_wrap) begin
              in_column <= '0;
              col_trk   <= '0;
              if (y_wrap) begin
                in_row  <= '0;
                row_trk <= '0;
              end else begin
                in_row  <= y_now + bdd_pkg::pos_t'(1);
                row_trk <= bdd_pkg::trk_step(rt_now, y_now, eff_sh, eff_oh);
              end
            end else begin
              in_column <= x_now + bdd_pkg::pos_t'(1);
              in_row    <= y_now;
              col_trk   <= bdd_pkg::trk_step(ct_now, x_now, eff_sw, eff_ow);
              row_trk   <= rt_now;
            end
          end
        end
        ST_INIT: begin
          rep_col <= '0;
          rep_row <= '0;
          col_trk <= '0;
          row_trk <= '0;
          state   <= ST_SYNC;
        end
        ST_SYNC: begin
          // replay the trackers from the origin under the new sizes
          if (rep_col != in_column) begin
            col_trk <= bdd_pkg::trk_step(col_trk, rep_col, eff_sw, eff_ow);
            rep_col <= rep_col + bdd_pkg::pos_t'(1);
          end
          if (rep_row != in_row) begin
            row_trk <= bdd_pkg::trk_step(row_trk, rep_row, eff_sh, eff_oh);
            rep_row <= rep_row + bdd_pkg::pos_t'(1);
          end
          if (rep_col == in_column && rep_row == in_row) state <= ST_RUN;
        end
        default: state <= ST_RUN;
      endcase
      if (cfg_valid && cfg_ready) state <= ST_INIT;
    end
  end

  // line buffers: line2 is written one stage late, so bypass a same-column write
  assign a1_b = b_inbuf ? rd1 : '0;
  assign a2_b = b_inbuf ? rd2 : '0;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd1 <= line1[addr_now];
      if (b_xfer && b_inbuf && b_addr == addr_now) rd2 <= a1_b;
      else rd2 <= line2[addr_now];
      if (inbuf_now) line1[addr_now] <= raw_value;
    end
    if (b_xfer && b_inbuf) line2[b_addr] <= a1_b;
  end

  // sample stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_acc) begin
      b_valid <= 1'b1;
    end else if (b_xfer) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_pix   <= raw_value;
      b_inbuf <= inbuf_now;
      b_addr  <= addr_now;
      b_cols  <= cols_now;
      b_rows  <= rows_now;
    end
  end

  // window stage: emits up to four words, rows outer, columns inner
  assign c_mask_rest = c_mask & (c_mask - 4'd1);
  assign d_load      = (c_mask != '0) && (!out_valid || !out_stall);
  assign c_free      = (c_mask == '0) || (d_load && c_mask_rest == '0);
  assign b_xfer      = b_valid && c_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_mask <= '0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (b_xfer) begin
      c_mask <= {b_rows.cur.en & b_cols.cur.en, b_rows.cur.en & b_cols.pre.en,
                 b_rows.pre.en & b_cols.cur.en, b_rows.pre.en & b_cols.pre.en};
      for (int r = 0; r < 3; r++) begin
        win[r*3]     <= win[r*3 + 1];
        win[r*3 + 1] <= win[r*3 + 2];
      end
      win[2] <= a2_b;
      win[5] <= a1_b;
      win[8] <= b_pix;
    end else if (d_load) begin
      c_mask <= c_mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (b_xfer) begin
      c_cols <= b_cols;
      c_rows <= b_rows;
    end
  end

  // pick the lowest pending word and demosaic it
  always_comb begin
    if (c_mask[0]) begin
      rsel = 1'b0; csel = 1'b0;
    end else if (c_mask[1]) begin
      rsel = 1'b0; csel = 1'b1;
    end else if (c_mask[2]) begin
      rsel = 1'b1; csel = 1'b0;
    end else begin
      rsel = 1'b1; csel = 1'b1;
    end
    ra      = rsel ? c_rows.cur : c_rows.pre;
    ca      = csel ? c_cols.cur : c_cols.pre;
    row_top = {win[2], win[1], win[0]};
    row_mid = {win[5], win[4], win[3]};
    row_bot = {win[8], win[7], win[6]};
    ctr_row = rsel ? row_bot : row_mid;
    if (rsel) up_row = ra.has_pre ? row_mid : row_bot;
    else      up_row = ra.has_pre ? row_top : row_mid;
    ci   = csel ? 2'd2 : 2'd1;
    lf_i = ca.has_pre ? ci - 2'd1 : ci;
    ctr  = ctr_row[ci*8 +: 8];
    hsum = {1'b0, ctr_row[lf_i*8 +: 8]} + {1'b0, ctr_row[23:16]};
    vsum = {1'b0, up_row[ci*8 +: 8]} + {1'b0, row_bot[ci*8 +: 8]};
    dsum = {2'b0, up_row[lf_i*8 +: 8]} + {2'b0, up_row[23:16]} +
           {2'b0, row_bot[lf_i*8 +: 8]} + {2'b0, row_bot[23:16]};
    gsum = {1'b0, hsum} + {1'b0, vsum};
    if (!ra.odd && !ca.odd) begin
      r_val = ctr;        g_val = gsum[9:2];  b_val = dsum[9:2];
    end else if (!ra.odd) begin
      g_val = ctr;        r_val = hsum[8:1];  b_val = vsum[8:1];
    end else if (!ca.odd) begin
      g_val = ctr;        r_val = vsum[8:1];  b_val = hsum[8:1];
    end else begin
      b_val = ctr;        g_val = gsum[9:2];  r_val = dsum[9:2];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= (c_mask != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (d_load) begin
      red        <= r_val;
      green      <= g_val;
      blue       <= b_val;
      out_column <= ca.d;
      out_row    <= ra.d;
      frame_done <= ra.last & ca.last;
      run_last   <= (c_mask_rest == '0);
    end
  end

`ifndef SYNTHESIS
  a_sync_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state != ST_RUN) |-> in_stall)
    else $error("sample taken while scaler trackers are being replayed");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> in_stall)
    else $error("sample taken right after a config write");

  a_run_is_gapless: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !run_last) |=> out_valid)
    else $error("gap inside a run of words from one sample");

  a_sync_finishes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SYNC && rep_col == in_column && rep_row == in_row &&
     !(cfg_valid && cfg_ready)) |=> (state == ST_RUN))
    else $error("tracker replay did not return to run");
`endif

endmodule

`default_nettype wire
